[rtl/prra_pkg.sv]
// Shared constants, types and register codes of the priority round-robin arbiter.
package prra_pkg;

   localparam int NUM_QUEUES     = 8;
   localparam int PRIORITY_BITS  = 3;
   localparam int QUEUE_BITS     = $clog2(NUM_QUEUES);
   localparam int LEVEL_COUNT    = 2 ** PRIORITY_BITS;
   localparam int COUNT_BITS     = $clog2(NUM_QUEUES + 1);
   localparam int PRIO_VEC_BITS  = NUM_QUEUES * PRIORITY_BITS;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = PRIO_VEC_BITS;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 8;

   typedef logic [QUEUE_BITS-1:0]    queue_idx_type;
   typedef logic [PRIORITY_BITS-1:0] level_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_QUEUE_COUNT      = 1'b0,
      CSR_QUEUE_PRIORITIES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic          valid;
      queue_idx_type queue;
      level_type     level;
   } grant_type;

endpackage

[rtl/prra_grant_logic.sv]
// Combinational grant decision: strict priority across levels, round-robin within a level.
module prra_grant_logic
   import prra_pkg::*;
(
   input  logic [NUM_QUEUES-1:0]    queue_nonempty,
   input  logic [COUNT_BITS-1:0]    queue_count,
   input  logic [PRIO_VEC_BITS-1:0] queue_priorities,
   input  queue_idx_type            level_ptr [LEVEL_COUNT],
   output grant_type                grant
);

   function automatic queue_idx_type lowest_set(input logic [NUM_QUEUES-1:0] vec);
      queue_idx_type result;
      result = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            result = QUEUE_BITS'(i);
         end
      end
      return result;
   endfunction

   logic [COUNT_BITS-1:0] used;
   logic [NUM_QUEUES-1:0] eligible;
   logic [LEVEL_COUNT-1:0] level_any;
   queue_idx_type          level_win [LEVEL_COUNT];

   assign used = (queue_count > COUNT_BITS'(NUM_QUEUES)) ? COUNT_BITS'(NUM_QUEUES) : queue_count;

   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         eligible[i] = queue_nonempty[i] && (COUNT_BITS'(i) < used);
      end
   end

   for (genvar l = 0; l < LEVEL_COUNT; l++) begin : g_level
      logic [NUM_QUEUES-1:0] member;
      logic [NUM_QUEUES-1:0] upper;

      always_comb begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            member[i] = eligible[i] &&
                        (queue_priorities[i*PRIORITY_BITS +: PRIORITY_BITS] == PRIORITY_BITS'(l));
            upper[i]  = member[i] && (QUEUE_BITS'(i) >= level_ptr[l]);
         end
      end

      assign level_any[l] = |member;
      assign level_win[l] = (|upper) ? lowest_set(upper) : lowest_set(member);
   end

   always_comb begin
      grant = '0;
      for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
         if (level_any[l]) begin
            grant.valid = 1'b1;
            grant.queue = level_win[l];
            grant.level = PRIORITY_BITS'(l);
         end
      end
   end

endmodule

[rtl/priority_round_robin_arbiter_top.sv]
// Top level of the strict-priority arbiter with round-robin service inside each level.
// Each request word carries the non-empty mask of the queues and yields one response word
// with grant_valid and the granted queue. The block takes one request word per cycle unless
// back-pressure stalls it. A request word is held in the input register, where the grant is
// decided, and then moves to the result register, which drives the response. Back-pressure
// on the response side stalls the input only when both registers are full. The per-level
// round-robin pointers start at queue 0 after reset and keep their values across
// configuration writes.
module priority_round_robin_arbiter_top
   import prra_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // Fields from bit 0: queue_nonempty.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // Fields from bit 0: grant_valid, grant_queue.
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [COUNT_BITS-1:0]    count_ff;
   logic [PRIO_VEC_BITS-1:0] prio_ff;
   queue_idx_type            level_ptr_ff [LEVEL_COUNT];

   logic                  in_valid_ff;
   logic [NUM_QUEUES-1:0] in_mask_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_grant_ff;
   queue_idx_type         rsp_queue_ff;

   logic          advance;
   logic          take_req;
   grant_type     grant;
   queue_idx_type next_ptr_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   prra_grant_logic u_grant (
      .queue_nonempty   (in_mask_ff),
      .queue_count      (count_ff),
      .queue_priorities (prio_ff),
      .level_ptr        (level_ptr_ff),
      .grant            (grant)
   );

   assign next_ptr_in = (grant.queue == QUEUE_BITS'(NUM_QUEUES - 1)) ? '0
                                                                     : grant.queue + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prio_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUEUE_COUNT:      count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_QUEUE_PRIORITIES: prio_ff  <= csr_wdata[PRIO_VEC_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVEL_COUNT; l++) begin
            level_ptr_ff[l] <= '0;
         end
      end else if (in_valid_ff && advance && grant.valid) begin
         level_ptr_ff[grant.level] <= next_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_mask_ff <= req_tdata[NUM_QUEUES-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_grant_ff <= grant.valid;
         rsp_queue_ff <= grant.queue;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_queue_ff, rsp_grant_ff});

   a_grant_is_eligible: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && grant.valid) |->
         (in_mask_ff[grant.queue] &&
          (prio_ff[grant.queue*PRIORITY_BITS +: PRIORITY_BITS] == grant.level)))
      else $error("Granted queue is empty or outside the granting level.");

   a_pointer_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && grant.valid) |=>
         (level_ptr_ff[$past(grant.level)] == $past(next_ptr_in)))
      else $error("Level pointer did not move past the granted queue.");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_mask_ff)))
      else $error("Stalled request word was lost or changed.");

endmodule

[verif/priority_round_robin_arbiter_top_tb.sv]
// Self-checking testbench for the strict-priority round-robin arbiter top level.
module priority_round_robin_arbiter_top_tb;
   import prra_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic          valid;
      queue_idx_type queue;
   } grant_word_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;   // Fields from bit 0: queue_nonempty.
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;   // Fields from bit 0: grant_valid, grant_queue.
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   logic [3:0]                model_count;
   logic [PRIO_VEC_BITS-1:0]  model_prio;
   queue_idx_type             level_ptr [LEVEL_COUNT];
   grant_word_type            pending_grants [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int fault_count = 0;
   int words_sent = 0;
   int grants_seen = 0;
   int empty_seen = 0;
   int csr_writes = 0;

   priority_round_robin_arbiter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("priority_round_robin_arbiter_top_tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Scans the levels from the lowest value up and advances the winning level's pointer.
   function automatic grant_word_type arbitrate(input logic [7:0] mask);
      grant_word_type g;
      int used;
      int idx;
      logic found;
      g = '0;
      found = 1'b0;
      used = (model_count > NUM_QUEUES) ? NUM_QUEUES : int'(model_count);
      for (int lvl = 0; lvl < LEVEL_COUNT && !found; lvl++) begin
         for (int k = 0; k < NUM_QUEUES && !found; k++) begin
            idx = (int'(level_ptr[lvl]) + k) % NUM_QUEUES;
            if (idx < used && int'(model_prio[idx*PRIORITY_BITS +: PRIORITY_BITS]) == lvl
                && mask[idx]) begin
               found = 1'b1;
               level_ptr[lvl] = queue_idx_type'((idx + 1) % NUM_QUEUES);
               g.valid = 1'b1;
               g.queue = queue_idx_type'(idx);
            end
         end
      end
      return g;
   endfunction

   task automatic check_grant(input logic [RSP_DATA_BITS-1:0] word);
      grant_word_type exp_grant;
      if (pending_grants.size() == 0) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT) begin
            $display("Unexpected response word %h at cycle %0d", word, cycle_count);
         end
      end else begin
         exp_grant = pending_grants.pop_front();
         if (word[0] !== exp_grant.valid || word[3:1] !== exp_grant.queue) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display({"Grant mismatch at cycle %0d: expected valid %0b queue %0d, ",
                         "got valid %0b queue %0d"},
                        cycle_count, exp_grant.valid, exp_grant.queue, word[0], word[3:1]);
            end
         end
         if (exp_grant.valid) begin
            grants_seen++;
         end else begin
            empty_seen++;
         end
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            check_grant(rsp_tdata);
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic send_word(input logic [7:0] mask);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= mask;
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      pending_grants.insert(pending_grants.size(), arbitrate(mask));
      words_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_config(input logic [3:0] count, input logic [PRIO_VEC_BITS-1:0] prio);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_QUEUE_COUNT;
      csr_wdata <= CSR_DATA_BITS'(count);
      @(posedge clock);
      model_count = count;
      csr_index <= CSR_QUEUE_PRIORITIES;
      csr_wdata <= prio;
      @(posedge clock);
      model_prio = prio;
      csr_we <= 1'b0;
      csr_writes += 2;
   endtask

   function automatic logic [7:0] random_mask();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         return 8'($urandom);
      end else if (pick < 70) begin
         return 8'($urandom & $urandom);
      end else if (pick < 85) begin
         return 8'(1 << $urandom_range(0, 7));
      end else if (pick < 95) begin
         return 8'hFF;
      end
      return 8'h00;
   endfunction

   task automatic random_config;
      logic [3:0] count;
      logic [PRIO_VEC_BITS-1:0] prio;
      level_type lvl_a;
      level_type lvl_b;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         count = 4'($urandom_range(1, 8));
      end else if (pick < 80) begin
         count = 4'd0;
      end else if (pick < 90) begin
         count = 4'd8;
      end else begin
         count = 4'($urandom_range(9, 15));
      end
      lvl_a = level_type'($urandom);
      lvl_b = level_type'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         prio = PRIO_VEC_BITS'($urandom);
      end else if (pick < 70) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            prio[i*PRIORITY_BITS +: PRIORITY_BITS] = $urandom_range(0, 1) ? lvl_a : lvl_b;
         end
      end else if (pick < 85) begin
         prio = {NUM_QUEUES{lvl_a}};
      end else begin
         prio = $urandom_range(0, 1) ? '1 : '0;
      end
      set_config(count, prio);
   endtask

   task automatic test_after_reset;
      send_word(8'hFF);
      send_word(8'h01);
   endtask

   task automatic test_single_level;
      set_config(4'd8, '0);
      send_word(8'hFF);
      send_word(8'hFF);
      send_word(8'hFF);
      send_word(8'h00);
      send_word(8'h80);
      send_word(8'h01);
   endtask

   task automatic test_strict_levels;
      logic [PRIO_VEC_BITS-1:0] prio;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         prio[i*PRIORITY_BITS +: PRIORITY_BITS] = level_type'(NUM_QUEUES - 1 - i);
      end
      set_config(4'd8, prio);
      send_word(8'hFF);
      send_word(8'h7F);
      send_word(8'h01);
   endtask

   task automatic test_unused_queues;
      set_config(4'd3, '1);
      send_word(8'hF8);
      send_word(8'hFF);
      send_word(8'hFF);
   endtask

   task automatic test_count_saturation;
      set_config(4'd15, '0);
      send_word(8'hFF);
      send_word(8'h80);
   endtask

   task automatic test_pointers_across_config;
      set_config(4'd8, '0);
      send_word(8'hFF);
      set_config(4'd4, 24'h000E38);
      send_word(8'hFF);
      send_word(8'h0F);
   endtask

   task automatic test_output_backpressure;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_config(4'd8, PRIO_VEC_BITS'($urandom));
      hold_left <= 64;
      for (int i = 0; i < 24; i++) begin
         send_word(random_mask());
      end
      drain();
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int blk = 0; blk < 4; blk++) begin
         random_config();
         for (int i = 0; i < count / 4; i++) begin
            send_word(random_mask());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_QUEUE_COUNT;
      csr_wdata = '0;
      model_count = '0;
      model_prio = '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         level_ptr[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_single_level();
      test_strict_levels();
      test_unused_queues();
      test_count_saturation();
      test_pointers_across_config();
      test_output_backpressure();
      test_random_phase(0, 0, 420);
      test_random_phase(79, 0, 420);
      test_random_phase(0, 79, 420);
      test_random_phase(10, 10, 420);
      set_config(4'd0, '0);
      send_word(8'hFF);

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d request words over %0d register writes; %0d grants and %0d empty.",
               words_sent, csr_writes, grants_seen, empty_seen);
      $display("Covered strict levels, ring rotation, unused queues, count saturation and stalls.");
      if (fault_count == 0 && pending_grants.size() == 0) begin
         $display("priority_round_robin_arbiter_top_tb OK");
      end else begin
         $display("priority_round_robin_arbiter_top_tb NOT OK");
      end
      $finish;
   end

endmodule
